[design/satq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted alarm timer queue package
// Shared constants, command codes and the front-to-back command item.
// ----------------------------------------------------------------------------
package satq_pkg;

   localparam int LIST_DEPTH_DEF = 16;
   localparam int NUM_TIMERS_DEF = 16;
   localparam int MAX_RESULTS    = 16;
   localparam int NFIRE_W        = $clog2(MAX_RESULTS + 1);

   localparam int CMD_W      = 2;
   localparam int ID_W       = 4;
   localparam int INTERVAL_W = 16;
   localparam int TIME_W     = 32;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   // raw command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

   localparam logic STATUS_FIRED  = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_START  = 2'd1,
      OP_CANCEL = 2'd2
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [ID_W-1:0]         id;
      logic [INTERVAL_W-1:0]   interval;
   } cmd_type;

endpackage

[design/satq_front.sv]
// ----------------------------------------------------------------------------
// Sorted alarm timer queue front end
// Accept request items, drop the ones without effect, queue the rest.
// ----------------------------------------------------------------------------
module satq_front #(
   parameter int NUM_TIMERS = satq_pkg::NUM_TIMERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [satq_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              cmd_valid,
   input  logic                              cmd_ready,
   output satq_pkg::cmd_type                 cmd_item
);
   import satq_pkg::*;

   logic [CMD_W-1:0]      req_cmd;
   logic [ID_W-1:0]       req_id;
   logic [INTERVAL_W-1:0] req_interval;
   logic                  id_ok;
   logic                  keep;
   cmd_type               item;

   cmd_type               slot_ff [2];
   cmd_type               slot_in [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            fill_ff, fill_in;
   logic                  push, pop;

   assign req_cmd      = req_tdata[CMD_W-1:0];
   assign req_id       = req_tdata[CMD_W+ID_W-1:CMD_W];
   assign req_interval = req_tdata[CMD_W+ID_W+INTERVAL_W-1:CMD_W+ID_W];
   assign id_ok        = 32'(req_id) < NUM_TIMERS;

   // classify: drop unknown commands and out-of-range timers
   always_comb begin
      keep          = 1'b0;
      item.op       = OP_TICK;
      item.id       = req_id;
      item.interval = req_interval;
      case (req_cmd)
         CMD_TICK: begin
            keep = 1'b1;
         end
         CMD_START: begin
            keep    = id_ok;
            item.op = OP_START;
         end
         CMD_CANCEL: begin
            keep    = id_ok;
            item.op = OP_CANCEL;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_tready = fill_ff != 2'd2;
   assign push       = req_tvalid && req_tready && keep;
   assign cmd_valid  = fill_ff != 2'd0;
   assign pop        = cmd_valid && cmd_ready;
   assign cmd_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = item;
         wr_ptr_in          = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      slot_ff <= slot_in;
   end

endmodule

[design/satq_back.sv]
// ----------------------------------------------------------------------------
// Sorted alarm timer queue back end
// Hold the sorted alarm list, run inserts, cancels and tick pops.
// ----------------------------------------------------------------------------
module satq_back #(
   parameter int LIST_DEPTH = satq_pkg::LIST_DEPTH_DEF,
   parameter int NUM_TIMERS = satq_pkg::NUM_TIMERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  satq_pkg::cmd_type                 cmd_item,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [satq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import satq_pkg::*;

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int TIX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CMP   = 5'b00010,
      ST_PUT   = 5'b00100,
      ST_POP   = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TIME_W-1:0]     dl_ff [LIST_DEPTH];
   logic [TIME_W-1:0]     dl_in [LIST_DEPTH];
   logic [ID_W-1:0]       tid_ff [LIST_DEPTH];
   logic [ID_W-1:0]       tid_in [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] lt_ff, lt_in;
   logic [NUM_TIMERS-1:0] active_ff, active_in;
   logic [TIME_W-1:0]     new_dl_ff, new_dl_in;
   logic [TIME_W-1:0]     key;
   logic [ID_W-1:0]       new_id_ff, new_id_in;
   logic [NFIRE_W-1:0]    nfire_ff, nfire_in;
   logic                  pend_ff, pend_in;
   logic [ID_W-1:0]       pend_id_ff, pend_id_in;
   logic                  out_valid_ff, out_valid_in;
   logic [ID_W-1:0]       out_id_ff, out_id_in;
   logic                  out_status_ff, out_status_in;
   logic                  out_last_ff, out_last_in;

   logic                  can_push;
   logic [TIME_W-1:0]     head_diff;
   logic                  head_due;
   logic                  head_act;
   logic                  full;
   logic [LIST_DEPTH-1:0] ge;
   logic [TIME_W-1:0]     rel;

   assign can_push   = !out_valid_ff || rsp_tready;
   assign full       = 32'(count_ff) == LIST_DEPTH;
   assign head_diff  = dl_ff[0] - now_ff;
   assign head_due   = (count_ff != '0) && (32'(nfire_ff) < MAX_RESULTS)
                    && (head_diff[TIME_W-1] || head_diff == '0);
   assign head_act   = active_ff[TIX_W'(tid_ff[0])];
   // new key relative to now is just the interval with the sign bit flipped
   assign key        = TIME_W'(new_dl_ff - now_ff) ^ {1'b1, {(TIME_W-1){1'b0}}};

   assign cmd_ready  = (state_ff == ST_IDLE)
                    && !(cmd_item.op == OP_START && full && !can_push);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_status_ff, out_id_ff});
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      dl_in         = dl_ff;
      tid_in        = tid_ff;
      lt_in         = lt_ff;
      active_in     = active_ff;
      new_dl_in     = new_dl_ff;
      new_id_in     = new_id_ff;
      nfire_in      = nfire_ff;
      pend_in       = pend_ff;
      pend_id_in    = pend_id_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_id_in     = out_id_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      ge            = '0;
      rel           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               case (cmd_item.op)
                  OP_TICK: begin
                     now_in   = now_ff + 1'b1;
                     nfire_in = '0;
                     pend_in  = 1'b0;
                     state_in = ST_POP;
                  end
                  OP_START: begin
                     if (full) begin
                        out_valid_in  = 1'b1;
                        out_id_in     = cmd_item.id;
                        out_status_in = STATUS_FULL;
                        out_last_in   = 1'b1;
                     end else begin
                        new_dl_in = now_ff + TIME_W'(cmd_item.interval);
                        new_id_in = cmd_item.id;
                        state_in  = ST_CMP;
                     end
                  end
                  OP_CANCEL: begin
                     active_in[TIX_W'(cmd_item.id)] = 1'b0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CMP: begin
            // each entry compares itself with the new key
            for (int i = 0; i < LIST_DEPTH; i++) begin
               rel      = (dl_ff[i] - now_ff) ^ {1'b1, {(TIME_W-1){1'b0}}};
               lt_in[i] = rel < key;
            end
            state_in = ST_PUT;
         end
         ST_PUT: begin
            // entries before the slot hold, the slot takes the new alarm, the rest shift up
            for (int i = 0; i < LIST_DEPTH; i++) begin
               ge[i] = !lt_ff[i] || (32'(i) >= 32'(count_ff));
            end
            for (int i = 0; i < LIST_DEPTH; i++) begin
               if (ge[i]) begin
                  if (i == 0 || !ge[(i == 0) ? 0 : i - 1]) begin
                     dl_in[i]  = new_dl_ff;
                     tid_in[i] = new_id_ff;
                  end else begin
                     dl_in[i]  = dl_ff[(i == 0) ? 0 : i - 1];
                     tid_in[i] = tid_ff[(i == 0) ? 0 : i - 1];
                  end
               end
            end
            count_in = count_ff + 1'b1;
            state_in = ST_IDLE;
         end
         ST_POP: begin
            if (head_due) begin
               if (!(head_act && pend_ff && !can_push)) begin
                  for (int i = 0; i + 1 < LIST_DEPTH; i++) begin
                     dl_in[i]  = dl_ff[i+1];
                     tid_in[i] = tid_ff[i+1];
                  end
                  count_in = count_ff - 1'b1;
                  if (head_act) begin
                     if (pend_ff) begin
                        out_valid_in  = 1'b1;
                        out_id_in     = pend_id_ff;
                        out_status_in = STATUS_FIRED;
                        out_last_in   = 1'b0;
                     end
                     pend_in    = 1'b1;
                     pend_id_in = tid_ff[0];
                     nfire_in   = nfire_ff + 1'b1;
                  end
               end
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_ff) begin
               state_in = ST_IDLE;
            end else if (can_push) begin
               out_valid_in  = 1'b1;
               out_id_in     = pend_id_ff;
               out_status_in = STATUS_FIRED;
               out_last_in   = 1'b1;
               pend_in       = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         count_ff     <= '0;
         active_ff    <= '1;
         pend_ff      <= 1'b0;
         nfire_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         nfire_ff     <= nfire_in;
         out_valid_ff <= out_valid_in;
      end
      dl_ff         <= dl_in;
      tid_ff        <= tid_in;
      lt_ff         <= lt_in;
      new_dl_ff     <= new_dl_in;
      new_id_ff     <= new_id_in;
      pend_id_ff    <= pend_id_in;
      out_id_ff     <= out_id_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= LIST_DEPTH)
      else $error("alarm list count beyond depth");

   a_fire_bound: assert property (@(posedge clock) disable iff (reset)
      32'(nfire_ff) <= MAX_RESULTS)
      else $error("too many firings for one tick");

   a_shrink_pop: assert property (@(posedge clock) disable iff (reset)
      (count_in < count_ff) |-> (state_ff == ST_POP))
      else $error("list shrank outside a tick pop");

   a_tick_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && cmd_valid && cmd_ready && cmd_item.op == OP_TICK)
      |=> (state_ff == ST_POP))
      else $error("tick did not start a pop pass");

endmodule

[design/sorted_alarm_timer_queue_core.sv]
// An accepted item is written into the front-end queue and offered to the back end
// from there. The back end runs a start through its compare and insert states, does a
// cancel in the idle state, and runs a tick through one pop step per due entry popped
// and then a flush step. A full-list reject result is written to the back end's output
// register. The back end takes one item at a time, and output stalls can hold it longer.
// Reset: synchronous active high; clears now, empties the list, re-arms all
// timers and empties the command queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Sorted alarm timer queue core
// Front end classifies request items into a short queue; back end keeps the
// deadline-sorted alarm list and emits fired timer IDs.
// ----------------------------------------------------------------------------
module sorted_alarm_timer_queue_core #(
   parameter int LIST_DEPTH = satq_pkg::LIST_DEPTH_DEF,
   parameter int NUM_TIMERS = satq_pkg::NUM_TIMERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] cmd, [5:2] timer_id, [21:6] interval_ticks, [23:22] zero
   input  logic [satq_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [3:0] fired_id, [4] status, [7:5] zero
   output logic [satq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import satq_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd_item;

   // front: drop meaningless items, buffer the rest in order
   satq_front #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd_item   (cmd_item)
   );

   // back: sorted list, tick pops and the output register
   satq_back #(
      .LIST_DEPTH (LIST_DEPTH),
      .NUM_TIMERS (NUM_TIMERS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd_item   (cmd_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[tb/tb_sorted_alarm_timer_queue_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted alarm timer queue core testbench
// Drives tick, start and cancel items over the request stream and checks the
// fired IDs, full rejects and last flags against a deadline-list predictor.
// ----------------------------------------------------------------------------
module tb_sorted_alarm_timer_queue_core;
   import satq_pkg::*;

   localparam int DEPTH       = LIST_DEPTH_DEF;
   localparam int TIMERS      = NUM_TIMERS_DEF;
   localparam int IDLE_LIMIT  = 20000;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [3:0] fired_id;
      logic       status;
      logic       last;
   } alarm_rsp_type;

   typedef struct {
      op_type     op;
      logic [3:0] id;
      logic [15:0] interval;
      logic [3:0] cmd_raw;   // bit 3 set: send raw code in bits 1:0 instead of op
      int         n_typed;   // expected results typed in, -1 = use predictor
      alarm_rsp_type typed_rsp;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   // predictor state
   logic [31:0] now_ticks;
   logic [31:0] alarm_deadline[$];
   logic [3:0]  alarm_owner[$];
   logic        armed[TIMERS];

   alarm_rsp_type expected_alarms[$];
   alarm_rsp_type last_predicted;
   stim_row_type  table_rows[$];
   int  predicted_count;
   int  error_count;
   int  rsp_seen;
   int  fire_seen;
   int  full_seen;
   int  idle_cycles;
   bit  quiet_phase;
   bit  hold_rsp;
   bit  stim_done;

   sorted_alarm_timer_queue_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [1:0] cmd, [5:2] timer_id, [21:6] interval
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [3:0] fired_id, [4] status
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Signed distance from now; the key orders deadlines across the wrap.
   function automatic logic [31:0] order_key(logic [31:0] deadline);
      return (deadline - now_ticks) ^ 32'h8000_0000;
   endfunction

   // Append one expectation to the result queue.
   function automatic void expect_rsp(alarm_rsp_type r);
      expected_alarms.insert(expected_alarms.size(), r);
      last_predicted = r;
      predicted_count++;
   endfunction

   // Advance the predictor by one item and queue the results it causes.
   function automatic void predict_alarms(logic [1:0] cmd, logic [3:0] id,
                                          logic [15:0] interval);
      logic [31:0] dl;
      logic [31:0] key;
      int pos;
      int n;
      logic [3:0] owner;
      alarm_rsp_type r;
      n = 0;
      if (cmd == CMD_TICK) begin
         now_ticks = now_ticks + 1;
         while (alarm_deadline.size() > 0 && n < MAX_RESULTS &&
                order_key(alarm_deadline[0]) <= 32'h8000_0000) begin
            owner = alarm_owner[0];
            alarm_deadline.delete(0);
            alarm_owner.delete(0);
            if (armed[owner]) begin
               r.fired_id = owner;
               r.status   = STATUS_FIRED;
               r.last     = 1'b0;
               expect_rsp(r);
               n++;
            end
         end
         if (n > 0) begin
            expected_alarms[$].last = 1'b1;
            last_predicted.last     = 1'b1;
         end
      end else if (cmd == CMD_START) begin
         if (alarm_deadline.size() >= DEPTH) begin
            r.fired_id = id;
            r.status   = STATUS_FULL;
            r.last     = 1'b1;
            expect_rsp(r);
         end else begin
            dl  = now_ticks + 32'(interval);
            key = order_key(dl);
            pos = 0;
            while (pos < alarm_deadline.size() && order_key(alarm_deadline[pos]) < key)
               pos++;
            alarm_deadline.insert(pos, dl);
            alarm_owner.insert(pos, id);
         end
      end else if (cmd == CMD_CANCEL) begin
         armed[id] = 1'b0;
      end
   endfunction

   // Offer one item, with a random gap first unless idling is off.
   task automatic send_item(logic [1:0] cmd, logic [3:0] id, logic [15:0] interval);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tdata  <= {2'b00, interval, id, cmd};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_alarms(cmd, id, interval);
      @(negedge clock);
   endtask

   // Receiver: random stall bursts, or a long hold counted here on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else
            rsp_tready <= 1'b1;
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      alarm_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen++;
         if (expected_alarms.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result id=%0d status=%0d last=%0d", $time,
                     rsp_tdata[3:0], rsp_tdata[4], rsp_tlast);
         end else begin
            want = expected_alarms[0];
            expected_alarms.delete(0);
            if (want.status == STATUS_FULL) full_seen++;
            else fire_seen++;
            if (rsp_tdata[3:0] !== want.fired_id) begin
               error_count++;
               $display("%0t: fired_id expected %0d actual %0d", $time,
                        want.fired_id, rsp_tdata[3:0]);
            end
            if (rsp_tdata[4] !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_tdata[4]);
            end
            if (rsp_tlast !== want.last) begin
               error_count++;
               $display("%0t: last expected %0d actual %0d", $time,
                        want.last, rsp_tlast);
            end
         end
      end
   end

   // Watchdog: count cycles where neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (!stim_done || expected_alarms.size() > 0)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, %0d results still expected", $time,
                  expected_alarms.size());
         $display("tb_sorted_alarm_timer_queue_core: errors");
         $finish;
      end
   end

   function automatic stim_row_type row(op_type op, logic [3:0] id, logic [15:0] iv,
                                        int n_typed, alarm_rsp_type typed_rsp);
      stim_row_type s;
      s.op = op; s.id = id; s.interval = iv; s.cmd_raw = 4'd0;
      s.n_typed = n_typed; s.typed_rsp = typed_rsp;
      return s;
   endfunction

   function automatic void add_row(stim_row_type s);
      table_rows.insert(table_rows.size(), s);
   endfunction

   initial begin
      stim_row_type s;
      int pred_before;
      int k;
      int choice;
      logic [1:0] cmd;
      logic [3:0] id;
      logic [15:0] iv;

      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0;
      error_count = 0; rsp_seen = 0; fire_seen = 0; full_seen = 0;
      predicted_count = 0; last_predicted = '0;
      idle_cycles = 0; quiet_phase = 0; hold_rsp = 0; stim_done = 0;
      now_ticks = '0;
      foreach (armed[i]) armed[i] = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows: typed results where obvious, predictor elsewhere.
      add_row(row(OP_TICK, 4'd0, 16'd0, 0, '0));        // empty tick
      add_row(row(OP_START, 4'd3, 16'd0, 0, '0));       // zero interval
      add_row(row(OP_TICK, 4'd0, 16'd0, 1, '{4'd3, 1'b0, 1'b1}));
      add_row(row(OP_START, 4'd15, 16'hFFFF, 0, '0));   // longest
      add_row(row(OP_START, 4'd0, 16'd2, 0, '0));
      add_row(row(OP_START, 4'd1, 16'd2, 0, '0));       // equal deadline
      add_row(row(OP_START, 4'd2, 16'd1, 0, '0));
      add_row(row(OP_CANCEL, 4'd2, 16'hFFFF, 0, '0));   // cancel then fire
      add_row(row(OP_TICK, 4'd0, 16'd0, -1, '0));
      add_row(row(OP_TICK, 4'd0, 16'd0, -1, '0));
      add_row(row(OP_START, 4'd2, 16'd0, 0, '0));       // start cancelled
      add_row(row(OP_START, 4'd5, 16'd0, 0, '0));
      add_row(row(OP_TICK, 4'd0, 16'd0, 1, '{4'd5, 1'b0, 1'b1}));
      s = row(OP_TICK, 4'd9, 16'h1234, 0, '0); s.cmd_raw = 4'b1011;  // unused code
      add_row(s);
      for (k = 0; k < 5; k++)                           // repeated start
         add_row(row(OP_START, 4'd7, 16'd3, 0, '0));
      add_row(row(OP_TICK, 4'd0, 16'd0, -1, '0));
      add_row(row(OP_TICK, 4'd0, 16'd0, -1, '0));
      add_row(row(OP_TICK, 4'd0, 16'd0, -1, '0));

      foreach (table_rows[i]) begin
         s = table_rows[i];
         pred_before = predicted_count;
         cmd = s.cmd_raw[3] ? s.cmd_raw[1:0] : 2'(s.op);
         send_item(cmd, s.id, s.interval);
         if (s.n_typed >= 0) begin
            if (predicted_count - pred_before != s.n_typed ||
                (s.n_typed == 1 && last_predicted != s.typed_rsp)) begin
               error_count++;
               $display("%0t: row %0d predictor disagrees with typed result", $time, i);
            end
         end
      end

      // Fill the list past full while the receiver holds off for a long
      // stretch, then drain it with a few ticks.
      hold_rsp = 1'b1;
      for (k = 0; k < DEPTH + 2; k++)
         send_item(CMD_START, 4'(k), 16'(k % 3));
      for (k = 0; k < 4; k++)
         send_item(CMD_TICK, 4'd0, 16'd0);
      req_tvalid <= 1'b0;
      wait (!hold_rsp);

      // Random part: mostly start/tick mixes with short intervals.
      for (k = 0; k < 280; k++) begin
         if (k == 240) quiet_phase = 1'b1;
         choice = $urandom_range(0, 99);
         id = 4'($urandom);
         if (choice < 45) begin
            cmd = CMD_START;
            iv = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
         end else if (choice < 90) begin
            cmd = CMD_TICK; iv = 16'($urandom);
         end else if (choice < 95) begin
            cmd = CMD_CANCEL; iv = 16'($urandom);
         end else begin
            cmd = 2'd3; iv = 16'($urandom);
         end
         send_item(cmd, id, iv);
      end
      for (k = 0; k < 30; k++) send_item(CMD_TICK, 4'd0, 16'd0);
      req_tvalid <= 1'b0;
      stim_done = 1'b1;

      while (expected_alarms.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Covered %0d results: %0d firings and %0d full rejects,", rsp_seen,
               fire_seen, full_seen);
      $display("including cancels, zero intervals, equal deadlines and a stalled fill.");
      if (error_count == 0)
         $display("tb_sorted_alarm_timer_queue_core: clean");
      else
         $display("tb_sorted_alarm_timer_queue_core: errors");
      $finish;
   end

endmodule
